/* src/baro_pressure_compensation_unit_macros.svh */
// assertion macros shared by the checker
`ifndef BARO_PRESSURE_COMPENSATION_UNIT_MACROS_SVH
`define BARO_PRESSURE_COMPENSATION_UNIT_MACROS_SVH

// property checked at each rising clock edge, off while reset is low
`define BPCU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal held steady over a stalled cycle
`define BPCU_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

/* src/bpcu_pkg.sv */
package bpcu_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned UT_W    = 16;
    localparam int unsigned UP_W    = 19;
    localparam int unsigned CFG_W   = 48;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] B6_OFFSET = 32'd4000;
    localparam logic [DATA_W-1:0] P_C1      = 32'd3038;
    localparam logic [DATA_W-1:0] P_C2      = 32'hFFFF_E343;   // -7357
    localparam logic [DATA_W-1:0] P_C3      = 32'd3791;
    localparam logic [DATA_W-1:0] P_SCALE   = 32'd50000;
    localparam logic [DATA_W-1:0] B4_OFFSET = 32'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_A = 3'd0,
        CFG_CAL_B = 3'd1,
        CFG_CAL_C = 3'd2,
        CFG_CAL_D = 3'd3,
        CFG_OSS   = 3'd4
    } t_cfg_idx;

    // carried beside the temperature divide
    typedef struct packed {
        logic [DATA_W-1:0] x1;
        logic [UP_W-1:0]   up;
        logic              neg;
        logic              dz;
    } t_div1_side;

    // carried beside the pressure divide
    typedef struct packed {
        logic [DATA_W-1:0] t;
        logic              big;
        logic              err;
    } t_div2_side;

    function automatic logic [DATA_W-1:0] f_asr(logic [DATA_W-1:0] v, int unsigned s);
        return DATA_W'($signed(v) >>> s);
    endfunction

    function automatic logic [DATA_W-1:0] f_sx16(logic [15:0] v);
        return {{(DATA_W-16){v[15]}}, v};
    endfunction

endpackage

/* src/bpcu_div.sv */
module bpcu_div
    import bpcu_pkg::*;
#(
    parameter int unsigned WIDTH  = DATA_W,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [WIDTH-1:0]  i_num,
    input  logic [WIDTH-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [WIDTH-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    // one quotient bit per stage, restoring
    logic [WIDTH-1:0]  w_rem  [WIDTH+1];
    logic [WIDTH-1:0]  w_num  [WIDTH+1];
    logic [WIDTH-1:0]  w_quo  [WIDTH+1];
    logic [WIDTH-1:0]  w_den  [WIDTH+1];
    logic [SIDE_W-1:0] w_side [WIDTH+1];
    logic              w_vld  [WIDTH+1];

    assign w_rem[0]  = '0;
    assign w_num[0]  = i_num;
    assign w_quo[0]  = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_valid;

    for (genvar g = 0; g < WIDTH; g++) begin : g_stage
        logic [WIDTH:0]    w_shift;
        logic [WIDTH:0]    w_diff;
        logic              w_fits;
        logic [WIDTH-1:0]  r_rem;
        logic [WIDTH-1:0]  r_num;
        logic [WIDTH-1:0]  r_quo;
        logic [WIDTH-1:0]  r_den;
        logic [SIDE_W-1:0] r_side;
        logic              r_vld;

        always_comb begin
            w_shift = {w_rem[g], w_num[g][WIDTH-1]};
            w_diff  = w_shift - {1'b0, w_den[g]};
            w_fits  = w_shift >= {1'b0, w_den[g]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_fits ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
                r_num  <= {w_num[g][WIDTH-2:0], 1'b0};
                r_quo  <= {w_quo[g][WIDTH-2:0], w_fits};
                r_den  <= w_den[g];
                r_side <= w_side[g];
            end
        end

        assign w_rem[g+1]  = r_rem;
        assign w_num[g+1]  = r_num;
        assign w_quo[g+1]  = r_quo;
        assign w_den[g+1]  = r_den;
        assign w_side[g+1] = r_side;
        assign w_vld[g+1]  = r_vld;
    end

    assign o_valid = w_vld[WIDTH];
    assign o_quo   = w_quo[WIDTH];
    assign o_side  = w_side[WIDTH];

endmodule

/* src/baro_pressure_compensation_unit.sv */
// channel    | direction | handshake               | payload
// input      | in        | i_valid / o_ready       | i_raw_temperature, i_raw_pressure
// result     | out       | o_valid / i_ready       | o_temperature_tenths, o_pressure_pa,
//            |           |                         | o_divide_error
// config     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item enters per cycle while the pipeline is not held; each item passes two 32-stage divide
// pipelines (one quotient bit per stage) and 12 arithmetic stages
// the whole pipeline moves together; it holds only while a result sits unaccepted
// in the output register, and o_ready follows that hold
// reset (synchronous, active low) clears valid bits and calibration registers
// config writes are always taken, o_cfg_ready is tied high
module baro_pressure_compensation_unit
    import bpcu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [UT_W-1:0]      i_raw_temperature,
    input  logic [UP_W-1:0]      i_raw_pressure,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DATA_W-1:0]    o_temperature_tenths,
    output logic [DATA_W-1:0]    o_pressure_pa,
    output logic                 o_divide_error,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // calibration registers
    logic [47:0] r_cal_a;
    logic [47:0] r_cal_b;
    logic [31:0] r_cal_c;
    logic [31:0] r_cal_d;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_cal_d <= '0;
            r_oss   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CAL_A: r_cal_a <= i_cfg_data;
                CFG_CAL_B: r_cal_b <= i_cfg_data;
                CFG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                CFG_CAL_D: r_cal_d <= i_cfg_data[31:0];
                CFG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // coefficients widened to 32 bits
    logic [DATA_W-1:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6;
    logic [DATA_W-1:0] w_b1, w_b2, w_mc, w_md;

    assign w_ac1 = f_sx16(r_cal_a[15:0]);
    assign w_ac2 = f_sx16(r_cal_a[31:16]);
    assign w_ac3 = f_sx16(r_cal_a[47:32]);
    assign w_ac4 = {16'd0, r_cal_b[15:0]};
    assign w_ac5 = {16'd0, r_cal_b[31:16]};
    assign w_ac6 = {16'd0, r_cal_b[47:32]};
    assign w_b1  = f_sx16(r_cal_c[15:0]);
    assign w_b2  = f_sx16(r_cal_c[31:16]);
    assign w_mc  = f_sx16(r_cal_d[15:0]);
    assign w_md  = f_sx16(r_cal_d[31:16]);

    // global advance: everything moves unless the output is stuck
    logic w_en;
    logic r12_vld;

    assign w_en    = !r12_vld || i_ready;
    assign o_ready = w_en;

    // stage valid bits
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld, r9_vld;
    logic r10_vld, r11_vld;
    logic w_d1_vld, w_d2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld  <= i_valid;
            r2_vld  <= r1_vld;
            r3_vld  <= w_d1_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= w_d2_vld;
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
        end
    end

    // stage 1: (ut - ac6) * ac5
    logic [DATA_W-1:0] r1_prod;
    logic [UP_W-1:0]   r1_up;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_prod <= ({16'd0, i_raw_temperature} - w_ac6) * w_ac5;
            r1_up   <= i_raw_pressure;
        end
    end

    // stage 2: x1, divisor x1 + md, operand magnitudes for the signed divide
    logic [DATA_W-1:0] n2_x1, n2_den, n2_num;
    logic [DATA_W-1:0] r2_x1, r2_nmag, r2_dmag;
    logic [UP_W-1:0]   r2_up;
    logic              r2_neg, r2_dz;

    always_comb begin
        n2_x1  = f_asr(r1_prod, 15);
        n2_den = n2_x1 + w_md;
        n2_num = w_mc << 11;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x1   <= n2_x1;
            r2_up   <= r1_up;
            r2_nmag <= n2_num[DATA_W-1] ? (DATA_W'(0) - n2_num) : n2_num;
            r2_dmag <= n2_den[DATA_W-1] ? (DATA_W'(0) - n2_den) : n2_den;
            r2_neg  <= n2_num[DATA_W-1] ^ n2_den[DATA_W-1];
            r2_dz   <= (n2_den == '0);
        end
    end

    // temperature divide: (mc << 11) / (x1 + md)
    t_div1_side        w_d1_in, w_d1_out;
    logic [DATA_W-1:0] w_d1_quo;

    assign w_d1_in = '{x1: r2_x1, up: r2_up, neg: r2_neg, dz: r2_dz};

    bpcu_div #(
        .WIDTH  (DATA_W),
        .SIDE_W ($bits(t_div1_side))
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_vld),
        .i_num   (r2_nmag),
        .i_den   (r2_dmag),
        .i_side  (w_d1_in),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_out)
    );

    // stage 3: b5 = x1 + x2
    logic [DATA_W-1:0] r3_b5;
    logic [UP_W-1:0]   r3_up;
    logic              r3_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_b5 <= w_d1_out.x1 + (w_d1_out.neg ? (DATA_W'(0) - w_d1_quo) : w_d1_quo);
            r3_up <= w_d1_out.up;
            r3_dz <= w_d1_out.dz;
        end
    end

    // stage 4: temperature result, b6 products
    logic [DATA_W-1:0] n4_b6;
    logic [DATA_W-1:0] r4_t, r4_b6sq, r4_ac2b6, r4_ac3b6;
    logic [UP_W-1:0]   r4_up;
    logic              r4_dz;

    assign n4_b6 = r3_b5 - B6_OFFSET;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_t     <= f_asr(r3_b5 + DATA_W'(8), 4);
            r4_b6sq  <= n4_b6 * n4_b6;
            r4_ac2b6 <= w_ac2 * n4_b6;
            r4_ac3b6 <= w_ac3 * n4_b6;
            r4_up    <= r3_up;
            r4_dz    <= r3_dz;
        end
    end

    // stage 5: scale the products
    logic [DATA_W-1:0] r5_t, r5_sq, r5_x2a, r5_x1c;
    logic [UP_W-1:0]   r5_up;
    logic              r5_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_t   <= r4_t;
            r5_sq  <= f_asr(r4_b6sq, 12);
            r5_x2a <= f_asr(r4_ac2b6, 11);
            r5_x1c <= f_asr(r4_ac3b6, 13);
            r5_up  <= r4_up;
            r5_dz  <= r4_dz;
        end
    end

    // stage 6: b2 * sq and b1 * sq
    logic [DATA_W-1:0] r6_t, r6_b2sq, r6_b1sq, r6_x2a, r6_x1c;
    logic [UP_W-1:0]   r6_up;
    logic              r6_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_t    <= r5_t;
            r6_b2sq <= w_b2 * r5_sq;
            r6_b1sq <= w_b1 * r5_sq;
            r6_x2a  <= r5_x2a;
            r6_x1c  <= r5_x1c;
            r6_up   <= r5_up;
            r6_dz   <= r5_dz;
        end
    end

    // stage 7: b3 (signed divide by 4 truncating toward zero) and x3 for b4
    logic [DATA_W-1:0] n7_x3a, n7_nb3;
    logic [DATA_W-1:0] r7_t, r7_b3, r7_x3b;
    logic [UP_W-1:0]   r7_up;
    logic              r7_dz;

    always_comb begin
        n7_x3a = f_asr(r6_b2sq, 11) + r6_x2a;
        n7_nb3 = (((w_ac1 << 2) + n7_x3a) << r_oss) + DATA_W'(2);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_t   <= r6_t;
            r7_b3  <= f_asr(n7_nb3 + (n7_nb3[DATA_W-1] ? DATA_W'(3) : DATA_W'(0)), 2);
            r7_x3b <= f_asr(r6_x1c + f_asr(r6_b1sq, 16) + DATA_W'(2), 2);
            r7_up  <= r6_up;
            r7_dz  <= r6_dz;
        end
    end

    // stage 8: ac4 * (x3 + 32768), up - b3
    logic [DATA_W-1:0] r8_t, r8_b4p, r8_upb3;
    logic              r8_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_t    <= r7_t;
            r8_b4p  <= w_ac4 * (r7_x3b + B4_OFFSET);
            r8_upb3 <= {{(DATA_W-UP_W){1'b0}}, r7_up} - r7_b3;
            r8_dz   <= r7_dz;
        end
    end

    // stage 9: b4 and b7
    logic [DATA_W-1:0] r9_t, r9_b4, r9_b7;
    logic              r9_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_t  <= r8_t;
            r9_b4 <= r8_b4p >> 15;
            r9_b7 <= r8_upb3 * (P_SCALE >> r_oss);
            r9_dz <= r8_dz;
        end
    end

    // pressure divide: b7 * 2 / b4, or b7 / b4 doubled afterwards when b7 is large
    t_div2_side        w_d2_in, w_d2_out;
    logic [DATA_W-1:0] w_d2_num, w_d2_quo;

    assign w_d2_num = r9_b7[DATA_W-1] ? r9_b7 : (r9_b7 << 1);
    assign w_d2_in  = '{t: r9_t, big: r9_b7[DATA_W-1], err: r9_dz || (r9_b4 == '0)};

    bpcu_div #(
        .WIDTH  (DATA_W),
        .SIDE_W ($bits(t_div2_side))
    ) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r9_vld),
        .i_num   (w_d2_num),
        .i_den   (r9_b4),
        .i_side  (w_d2_in),
        .o_valid (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_out)
    );

    // stage 10: p, (p >> 8)^2 and -7357 * p
    logic [DATA_W-1:0] n10_p, n10_p8;
    logic [DATA_W-1:0] r10_t, r10_p, r10_pp, r10_m2;
    logic              r10_err;

    always_comb begin
        n10_p  = w_d2_out.big ? (w_d2_quo << 1) : w_d2_quo;
        n10_p8 = f_asr(n10_p, 8);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_t   <= w_d2_out.t;
            r10_p   <= n10_p;
            r10_pp  <= n10_p8 * n10_p8;
            r10_m2  <= P_C2 * n10_p;
            r10_err <= w_d2_out.err;
        end
    end

    // stage 11: x1 * 3038, x2 = (-7357 * p) >> 16
    logic [DATA_W-1:0] r11_t, r11_p, r11_x1m, r11_x2;
    logic              r11_err;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_t   <= r10_t;
            r11_p   <= r10_p;
            r11_x1m <= r10_pp * P_C1;
            r11_x2  <= f_asr(r10_m2, 16);
            r11_err <= r10_err;
        end
    end

    // stage 12: final pressure correction into the output register
    logic [DATA_W-1:0] n12_p;
    logic [DATA_W-1:0] r12_t, r12_p;
    logic              r12_err;

    assign n12_p = r11_p + f_asr(f_asr(r11_x1m, 16) + r11_x2 + P_C3, 4);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_t   <= r11_err ? '0 : r11_t;
            r12_p   <= r11_err ? '0 : n12_p;
            r12_err <= r11_err;
        end
    end

    assign o_valid              = r12_vld;
    assign o_temperature_tenths = r12_t;
    assign o_pressure_pa        = r12_p;
    assign o_divide_error       = r12_err;

endmodule

/* src/bpcu_chk.sv */
`include "baro_pressure_compensation_unit_macros.svh"

module bpcu_chk
    import bpcu_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [UT_W-1:0]      i_raw_temperature,
    input logic [UP_W-1:0]      i_raw_pressure,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [DATA_W-1:0]    o_temperature_tenths,
    input logic [DATA_W-1:0]    o_pressure_pa,
    input logic                 o_divide_error,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data
);

    // a stalled result stays offered
    `BPCU_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "result dropped")

    // a stalled result keeps its pressure
    `BPCU_ASSERT_HOLD(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready,
        o_pressure_pa, "result changed")

    // input stalls only behind an unaccepted result
    `BPCU_ASSERT(a_ready_rule, i_clk, i_rst_n, o_ready == (!o_valid || i_ready), "bad ready")

    // divide error forces zero outputs
    `BPCU_ASSERT(a_err_zero, i_clk, i_rst_n, (o_valid && o_divide_error) |->
        (o_temperature_tenths == '0 && o_pressure_pa == '0), "nonzero on error")

endmodule

bind baro_pressure_compensation_unit bpcu_chk u_bpcu_chk (.*);
